// ===== rtl/spaced_seed_key_extractor_defines.svh =====
// Assertion macros for the spaced seed key extractor.
// Used by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SPACED_SEED_KEY_EXTRACTOR_DEFINES_SVH
`define SPACED_SEED_KEY_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted
`define SSK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define SSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ssk_pkg.sv =====
// Shared types and constants for the spaced seed key extractor.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ssk_pkg;

  // Default sizing
  localparam int SSK_MAX_SEED_LENGTH = 128;
  localparam int SSK_MAX_WEIGHT      = 64;
  localparam int SSK_MIN_WEIGHT      = 5;

  // Field widths
  localparam int SSK_SYM_W      = 2;
  localparam int SSK_MASK_W     = 64;
  localparam int SSK_MASK_BITS  = 2 * SSK_MASK_W;
  localparam int SSK_LEN_W      = 8;
  localparam int SSK_POS_W      = 32;
  localparam int SSK_BUCKET_W   = 16;
  localparam int SSK_PLO_W      = 64;
  localparam int SSK_PHI_W      = 48;
  localparam int SSK_PBYTES_W   = 4;
  localparam int SSK_PAY_BYTES  = 14;
  localparam int SSK_PAY_W      = SSK_PLO_W + SSK_PHI_W;
  localparam int SSK_PREF_W     = 5;

  // Widest key plus room for a bucket read past its top
  localparam int SSK_KEYP_W     = 2 * SSK_MAX_WEIGHT + SSK_BUCKET_W;

  // Configuration port
  localparam int SSK_CFG_IDX_W  = 2;
  localparam int SSK_CFG_DATA_W = 64;

  localparam logic [SSK_CFG_IDX_W-1:0] SSK_REG_MASK_LOW    = 2'd0;
  localparam logic [SSK_CFG_IDX_W-1:0] SSK_REG_MASK_HIGH   = 2'd1;
  localparam logic [SSK_CFG_IDX_W-1:0] SSK_REG_SEED_LENGTH = 2'd2;

  typedef logic [SSK_SYM_W-1:0] ssk_sym_t;

  // Key format derived from the seed, handed from the seed table to the datapath
  typedef struct packed {
    logic                    busy;   // selector scan in progress
    logic                    wt_ok;  // weight within the supported range
    logic [SSK_PBYTES_W-1:0] n8;     // whole payload bytes
    logic [SSK_PREF_W-1:0]   pref;   // bucket width in bits
  } ssk_fmt_t;

endpackage

`default_nettype wire

// ===== rtl/ssk_if.sv =====
// Valid/ready channel interfaces for the symbol input and the key result.
// Depends on ssk_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ssk_in_if import ssk_pkg::*; ();
  logic     valid;
  logic     ready;
  ssk_sym_t symbol;
  logic     chunk_start;

  modport source (output valid, symbol, chunk_start, input ready);
  modport sink   (input valid, symbol, chunk_start, output ready);
endinterface

interface ssk_out_if import ssk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [SSK_POS_W-1:0]    position;
  logic [SSK_BUCKET_W-1:0] bucket;
  logic [SSK_PLO_W-1:0]    payload_low;
  logic [SSK_PHI_W-1:0]    payload_high;
  logic [SSK_PBYTES_W-1:0] payload_bytes;

  modport source (output valid, position, bucket, payload_low, payload_high, payload_bytes,
                  input ready);
  modport sink   (input valid, position, bucket, payload_low, payload_high, payload_bytes,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/ssk_seed_table.sv =====
// Configuration registers and the gather selector table built by a scan of the mask.
// Depends on ssk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssk_seed_table import ssk_pkg::*; #(
  parameter int MAX_SEED_LENGTH = SSK_MAX_SEED_LENGTH,
  parameter int MAX_WEIGHT      = SSK_MAX_WEIGHT,
  localparam int IW  = $clog2(MAX_SEED_LENGTH),
  localparam int LW  = $clog2(MAX_SEED_LENGTH + 1),
  localparam int WIW = $clog2(MAX_WEIGHT)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [SSK_CFG_IDX_W-1:0]  cfg_index,
  input  logic [SSK_CFG_DATA_W-1:0] cfg_data,
  output logic [LW-1:0]             len_eff,
  output logic [MAX_WEIGHT-1:0][IW-1:0] sel,
  output ssk_fmt_t                  fmt
);

  logic [SSK_MASK_W-1:0]   mask_lo_r;
  logic [SSK_MASK_W-1:0]   mask_hi_r;
  logic [SSK_LEN_W-1:0]    seed_len_r;
  logic                    busy_r;
  logic [IW-1:0]           idx_r;
  logic [LW-1:0]           cnt_r;
  logic [MAX_WEIGHT-1:0][IW-1:0] sel_r;
  logic                    wt_ok_r;
  logic [SSK_PBYTES_W-1:0] n8_r;
  logic [SSK_PREF_W-1:0]   pref_r;

  logic [SSK_MASK_BITS-1:0] mask_all;
  logic [31:0]             idx_ext;
  logic                    mbit;
  logic                    last;
  logic [LW-1:0]           cnt_nxt;
  logic                    wt_ok_nxt;
  logic [SSK_PBYTES_W-1:0] n8_nxt;
  logic [SSK_PREF_W-1:0]   pref_nxt;

  // Clamp the programmed length into the supported span
  always_comb begin
    int l;
    l = int'(seed_len_r);
    if (l < 1) l = 1;
    if (l > MAX_SEED_LENGTH) l = MAX_SEED_LENGTH;
    len_eff = LW'(l);
  end

  // Mask bit under the scan pointer; offsets past the mask read as zero
  assign mask_all = {mask_hi_r, mask_lo_r};
  assign idx_ext  = 32'(idx_r);
  assign mbit     = (idx_ext < 32'(SSK_MASK_BITS)) ? mask_all[idx_ext[6:0]] : 1'b0;
  assign last     = (int'(idx_r) + 1 >= int'(len_eff));
  assign cnt_nxt  = cnt_r + LW'(mbit);

  // Derive bucket width and payload size from the final weight
  always_comb begin
    int wt;
    int r;
    int p;
    wt = int'(cnt_nxt);
    r  = 2 * (wt % 4);
    p  = (r == 0) ? SSK_BUCKET_W : 8 + r;
    wt_ok_nxt = (wt >= SSK_MIN_WEIGHT) && (wt <= MAX_WEIGHT);
    pref_nxt  = SSK_PREF_W'(p);
    n8_nxt    = wt_ok_nxt ? SSK_PBYTES_W'((2 * wt - p) / 8) : '0;
  end

  // Config writes; any write restarts the selector scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_lo_r  <= SSK_MASK_W'(1);
      mask_hi_r  <= '0;
      seed_len_r <= SSK_LEN_W'(1);
      busy_r     <= 1'b1;
      idx_r      <= '0;
      cnt_r      <= '0;
      wt_ok_r    <= 1'b0;
      n8_r       <= '0;
      pref_r     <= SSK_PREF_W'(SSK_BUCKET_W);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        SSK_REG_MASK_LOW:    mask_lo_r  <= cfg_data;
        SSK_REG_MASK_HIGH:   mask_hi_r  <= cfg_data;
        SSK_REG_SEED_LENGTH: seed_len_r <= cfg_data[SSK_LEN_W-1:0];
        default: ;
      endcase
      busy_r <= 1'b1;
      idx_r  <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_nxt;
      if (last) begin
        busy_r  <= 1'b0;
        wt_ok_r <= wt_ok_nxt;
        n8_r    <= n8_nxt;
        pref_r  <= pref_nxt;
      end else begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  // Record the window offset of each selected symbol, newest-first indexing
  always_ff @(posedge clk) begin
    if (rst_n && !cfg_wr_en && busy_r && mbit && (int'(cnt_r) < MAX_WEIGHT)) begin
      sel_r[WIW'(cnt_r)] <= IW'(int'(len_eff) - 1 - int'(idx_r));
    end
  end

  assign sel      = sel_r;
  assign fmt.busy  = busy_r;
  assign fmt.wt_ok = wt_ok_r;
  assign fmt.n8    = n8_r;
  assign fmt.pref  = pref_r;

endmodule

`default_nettype wire

// ===== rtl/ssk_extract.sv =====
// Symbol window, position counter, masked gather and the result register.
// Depends on ssk_pkg, ssk_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "spaced_seed_key_extractor_defines.svh"

module ssk_extract import ssk_pkg::*; #(
  parameter int MAX_SEED_LENGTH = SSK_MAX_SEED_LENGTH,
  parameter int MAX_WEIGHT      = SSK_MAX_WEIGHT,
  localparam int IW = $clog2(MAX_SEED_LENGTH),
  localparam int LW = $clog2(MAX_SEED_LENGTH + 1),
  localparam int KW = 2 * MAX_WEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ssk_in_if.sink                        in_ch,
  ssk_out_if.source                     out_ch,
  input  logic [LW-1:0]                 len_eff,
  input  logic [MAX_WEIGHT-1:0][IW-1:0] sel,
  input  ssk_fmt_t                      fmt
);

  // Input register
  logic     in_valid_r;
  ssk_sym_t sym_r;
  logic     cs_r;

  // Stream state
  logic [MAX_SEED_LENGTH-1:0][SSK_SYM_W-1:0] win_r;
  logic [LW-1:0]        fill_r;
  logic [SSK_POS_W-1:0] cnt_r;

  // Result register
  logic                    out_valid_r;
  logic [SSK_POS_W-1:0]    pos_r;
  logic [SSK_BUCKET_W-1:0] bucket_r;
  logic [SSK_PLO_W-1:0]    plo_r;
  logic [SSK_PHI_W-1:0]    phi_r;
  logic [SSK_PBYTES_W-1:0] pb_r;

  logic                    advance;
  logic                    proc;
  logic                    in_ready;
  logic                    in_fire;
  logic [LW-1:0]           fill_base;
  logic [LW-1:0]           fill_nxt;
  logic                    full;
  logic                    emit;
  logic [KW-1:0]           key;
  logic [SSK_KEYP_W-1:0]   keyp;
  logic [SSK_BUCKET_W-1:0] bucket_raw;
  logic [SSK_BUCKET_W:0]   bmask;
  logic [SSK_PAY_W-1:0]    pay;
  logic [SSK_POS_W-1:0]    pos_nxt;

  // Handshake: the result register parts the two sides
  assign advance  = !out_valid_r || out_ch.ready;
  assign proc     = in_valid_r && advance && !fmt.busy;
  assign in_ready = !fmt.busy && (!in_valid_r || proc);
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // Fill count after this item, saturating at the window depth
  assign fill_base = cs_r ? '0 : fill_r;
  assign fill_nxt  = (int'(fill_base) < MAX_SEED_LENGTH) ? fill_base + LW'(1) : fill_base;
  assign full      = (fill_nxt >= len_eff);
  assign emit      = proc && full && fmt.wt_ok;

  // Gather selected symbols; offset zero is the symbol entering now
  always_comb begin
    for (int w = 0; w < MAX_WEIGHT; w++) begin
      if (sel[w] == '0) key[2*w +: 2] = sym_r;
      else              key[2*w +: 2] = win_r[sel[w] - IW'(1)];
    end
  end

  // Split the key into bucket and payload bytes
  assign keyp       = SSK_KEYP_W'(key);
  assign bucket_raw = keyp[{fmt.n8, 3'b000} +: SSK_BUCKET_W];
  assign bmask      = ((SSK_BUCKET_W + 1)'(1) << fmt.pref) - (SSK_BUCKET_W + 1)'(1);

  always_comb begin
    for (int j = 0; j < SSK_PAY_BYTES; j++) begin
      pay[8*j +: 8] = (SSK_PBYTES_W'(j) < fmt.n8) ? keyp[8*j +: 8] : 8'd0;
    end
  end

  assign pos_nxt = cnt_r - (SSK_POS_W'(len_eff) - SSK_POS_W'(1));

  // Input register: take an item whenever the slot is free or draining and no scan runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sym_r <= in_ch.symbol;
      cs_r  <= in_ch.chunk_start;
    end
  end

  // Advance the stream state once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
    end else if (proc) begin
      fill_r <= fill_nxt;
      cnt_r  <= cnt_r + SSK_POS_W'(1);
    end
  end

  // Shift the window; contents before the first write are never read
  always_ff @(posedge clk) begin
    if (proc) begin
      win_r <= {win_r[MAX_SEED_LENGTH-2:0], sym_r};
    end
  end

  // Result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pos_r    <= pos_nxt;
      bucket_r <= bucket_raw & bmask[SSK_BUCKET_W-1:0];
      plo_r    <= pay[SSK_PLO_W-1:0];
      phi_r    <= pay[SSK_PAY_W-1:SSK_PLO_W];
      pb_r     <= fmt.n8;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.position      = pos_r;
  assign out_ch.bucket        = bucket_r;
  assign out_ch.payload_low   = plo_r;
  assign out_ch.payload_high  = phi_r;
  assign out_ch.payload_bytes = pb_r;

  // Checks
  `SSK_ASSERT_NOW(a_no_take_in_scan, fmt.busy, !in_ready, "item taken during selector scan")
  `SSK_ASSERT_NOW(a_emit_fmt_ok, emit, fmt.wt_ok && !fmt.busy, "result with unusable seed")
  `SSK_ASSERT_NEXT(a_cnt_step, proc, cnt_r == $past(cnt_r) + SSK_POS_W'(1), "counter missed step")
  `SSK_ASSERT_NEXT(a_cnt_hold, !proc, $stable(cnt_r), "counter moved without an item")

endmodule

`default_nettype wire

// ===== rtl/spaced_seed_key_extractor.sv =====
// Channel  | Dir | Fields
// ---------+-----+-----------------------------------------------------------
// in_ch    | in  | symbol[1:0], chunk_start
// out_ch   | out | position[31:0], bucket[15:0], payload_low/high, payload_bytes
// cfg_*    | in  | cfg_wr_en, cfg_index[1:0], cfg_data[63:0] (write only)
//
// One item per cycle sustained while results are taken; an accepted item is held in the
// input register, then its result is loaded into the result register.
// After reset and after every config write, the selector scan walks the mask one
// offset per cycle up to the effective seed length (1 to MAX_SEED_LENGTH), in_ready low.
// A stalled result holds in the result register; one more item waits in the input
// register, then in_ready drops until the result is taken.
// Top level of the spaced seed key extractor; depends on ssk_pkg, ssk_if,
// ssk_seed_table and ssk_extract.
`timescale 1ns / 1ps
`default_nettype none

module spaced_seed_key_extractor import ssk_pkg::*; #(
  parameter int MAX_SEED_LENGTH = SSK_MAX_SEED_LENGTH,
  parameter int MAX_WEIGHT      = SSK_MAX_WEIGHT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [SSK_CFG_IDX_W-1:0]  cfg_index,
  input  logic [SSK_CFG_DATA_W-1:0] cfg_data,
  ssk_in_if.sink                    in_ch,
  ssk_out_if.source                 out_ch
);

  localparam int IW = $clog2(MAX_SEED_LENGTH);
  localparam int LW = $clog2(MAX_SEED_LENGTH + 1);

  logic [LW-1:0]                 len_eff;
  logic [MAX_WEIGHT-1:0][IW-1:0] sel;
  ssk_fmt_t                      fmt;

  // Seed registers and selector table
  ssk_seed_table #(
    .MAX_SEED_LENGTH (MAX_SEED_LENGTH),
    .MAX_WEIGHT      (MAX_WEIGHT)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .len_eff   (len_eff),
    .sel       (sel),
    .fmt       (fmt)
  );

  // Window, gather and result stage
  ssk_extract #(
    .MAX_SEED_LENGTH (MAX_SEED_LENGTH),
    .MAX_WEIGHT      (MAX_WEIGHT)
  ) u_extract (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .len_eff (len_eff),
    .sel     (sel),
    .fmt     (fmt)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for spaced_seed_key_extractor: symbols and seed settings in,
// keys checked against a scoreboard that predicts each key from the symbol stream.
// Depends on ssk_pkg, the channel interfaces in ssk_if and the extractor RTL.
`timescale 1ns / 1ps

module testbench import ssk_pkg::*; ();

  localparam int unsigned LIMIT      = 400000;
  localparam int unsigned RAND_ITEMS = 1750;

  typedef struct packed {
    logic [SSK_POS_W-1:0]    position;
    logic [SSK_BUCKET_W-1:0] bucket;
    logic [SSK_PLO_W-1:0]    pay_lo;
    logic [SSK_PHI_W-1:0]    pay_hi;
    logic [SSK_PBYTES_W-1:0] pay_bytes;
  } key_t;

  // Seed state mirror, key predictor and store of keys still due
  class seed_key_scoreboard;
    logic [SSK_MASK_BITS-1:0] mask;
    logic [SSK_LEN_W-1:0]     seed_len;
    ssk_sym_t                 win[SSK_MAX_SEED_LENGTH];  // win[0] is the newest symbol
    int unsigned              fill_cnt;
    logic [SSK_POS_W-1:0]     sym_cnt;
    key_t                     keys_due[$];
    int unsigned              noted, checked, errors, printed;

    function new();
      mask     = 128'h1;
      seed_len = 8'd1;
      fill_cnt = 0;
      sym_cnt  = '0;
      noted    = 0;
      checked  = 0;
      errors   = 0;
      printed  = 0;
      foreach (win[i]) win[i] = '0;
    endfunction

    function void write_reg(logic [SSK_CFG_IDX_W-1:0] idx, logic [SSK_CFG_DATA_W-1:0] d);
      case (idx)
        SSK_REG_MASK_LOW:    mask[63:0]   = d;
        SSK_REG_MASK_HIGH:   mask[127:64] = d;
        SSK_REG_SEED_LENGTH: seed_len     = d[SSK_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Shift the symbol in and queue the key it completes, if any
    function void note_symbol(ssk_sym_t s, logic cs);
      int unsigned span, wt, w, r, pref, n8, i;
      logic [SSK_MASK_BITS-1:0] key_bits, upper, pay;
      logic [SSK_POS_W-1:0]     cur;
      key_t                     k;
      span = (seed_len == 0) ? 1 :
             ((seed_len > SSK_MAX_SEED_LENGTH) ? SSK_MAX_SEED_LENGTH : seed_len);
      cur = sym_cnt;
      noted++;
      if (cs) fill_cnt = 0;
      for (i = SSK_MAX_SEED_LENGTH - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = s;
      if (fill_cnt < SSK_MAX_SEED_LENGTH) fill_cnt++;
      sym_cnt = cur + 1;
      if (fill_cnt < span) return;

      // mask bits past the span never count
      wt = 0;
      for (i = 0; i < span; i++) wt += mask[i];
      if (wt < SSK_MIN_WEIGHT || wt > SSK_MAX_WEIGHT) return;

      // gather selected symbols, oldest offset first, two bits each
      key_bits = '0;
      w = 0;
      for (i = 0; i < span; i++) begin
        if (mask[i]) begin
          key_bits[2*w +: 2] = win[span-1-i];
          w++;
        end
      end

      // bucket takes what is left above the whole payload bytes
      r    = (2 * wt) % 8;
      pref = (r == 0) ? 16 : 8 + r;
      n8   = (2 * wt - pref) / 8;
      upper = key_bits >> (8 * n8);
      pay   = key_bits & ((128'h1 << (8 * n8)) - 1);

      k.position  = cur - SSK_POS_W'(span - 1);
      k.bucket    = upper[SSK_BUCKET_W-1:0];  // key bits above 2*weight are zero
      k.pay_lo    = pay[63:0];
      k.pay_hi    = pay[111:64];
      k.pay_bytes = SSK_PBYTES_W'(n8);
      keys_due.push_back(k);
    endfunction

    task report_mismatch(string what, logic [127:0] got, logic [127:0] want);
      errors++;
      if (printed < 40) begin
        $display("mismatch on key %0d: %s got %0h expected %0h", checked, what, got, want);
        printed++;
      end
    endtask

    task check_key(key_t got);
      key_t want;
      if (keys_due.size() == 0) begin
        report_mismatch("key with none due, position", 128'(got.position), '0);
        return;
      end
      want = keys_due.pop_front();
      checked++;
      if (got.position !== want.position)
        report_mismatch("position", 128'(got.position), 128'(want.position));
      if (got.bucket !== want.bucket)
        report_mismatch("bucket", 128'(got.bucket), 128'(want.bucket));
      if (got.pay_lo !== want.pay_lo)
        report_mismatch("payload_low", 128'(got.pay_lo), 128'(want.pay_lo));
      if (got.pay_hi !== want.pay_hi)
        report_mismatch("payload_high", 128'(got.pay_hi), 128'(want.pay_hi));
      if (got.pay_bytes !== want.pay_bytes)
        report_mismatch("payload_bytes", 128'(got.pay_bytes), 128'(want.pay_bytes));
    endtask
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [SSK_CFG_IDX_W-1:0]  cfg_index;
  logic [SSK_CFG_DATA_W-1:0] cfg_data;

  ssk_in_if  in_ch ();
  ssk_out_if out_ch ();

  spaced_seed_key_extractor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  seed_key_scoreboard sb;
  int unsigned        cycles     = 0;
  int unsigned        burst_left = 1;
  int unsigned        chunk_left = 0;
  int unsigned        settings   = 0;
  logic [5:0]         stall_tick = '0;
  logic [7:0]         stall_pat  = 8'hFF;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d keys still due", cycles, sb.keys_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: rotate a stall pattern, pick a fresh one each time the 6-bit tick wraps
  always @(posedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == 0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'h80 | 8'($urandom_range(0, 255)));
    end else begin
      stall_pat <= {stall_pat[0], stall_pat[7:1]};
    end
    out_ch.ready <= stall_pat[0];
  end

  // Check every key taken off the result channel
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      sb.check_key({out_ch.position, out_ch.bucket, out_ch.payload_low,
                    out_ch.payload_high, out_ch.payload_bytes});
  end

  // Offer one item, hold it until taken, then pace the next burst
  task automatic send_item(input ssk_sym_t s, input logic cs);
    int unsigned gap;
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= s;
    in_ch.chunk_start <= cs;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_symbol(s, cs);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid, wait for every due key, then let the pipeline settle
  task automatic drain(input int unsigned settle);
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (sb.keys_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_seed(input logic [SSK_MASK_BITS-1:0] m, input logic [SSK_LEN_W-1:0] lv);
    cfg_wr_en <= 1'b1;
    cfg_index <= SSK_REG_MASK_LOW;
    cfg_data  <= m[63:0];
    sb.write_reg(SSK_REG_MASK_LOW, m[63:0]);
    @(posedge clk);
    cfg_index <= SSK_REG_MASK_HIGH;
    cfg_data  <= m[127:64];
    sb.write_reg(SSK_REG_MASK_HIGH, m[127:64]);
    @(posedge clk);
    cfg_index <= SSK_REG_SEED_LENGTH;
    cfg_data  <= SSK_CFG_DATA_W'(lv);
    sb.write_reg(SSK_REG_SEED_LENGTH, SSK_CFG_DATA_W'(lv));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  // Choose a seed: fixed extremes first, then mostly short spans of legal weight
  task automatic pick_seed(input int unsigned ph, output logic [SSK_MASK_BITS-1:0] m,
                           output logic [SSK_LEN_W-1:0] lv, output int unsigned span);
    int unsigned wt, cnt, idx, roll;
    logic [SSK_MASK_BITS-1:0] junk;
    roll = $urandom_range(0, 99);
    case (ph)
      0: begin
        span = SSK_MAX_SEED_LENGTH;
        wt   = SSK_MAX_WEIGHT;
      end
      1: begin
        span = 64;
        wt   = SSK_MAX_WEIGHT;
      end
      2: begin
        span = SSK_MAX_SEED_LENGTH;
        wt   = $urandom_range(SSK_MIN_WEIGHT, SSK_MAX_WEIGHT);
      end
      3: begin
        span = 100;
        wt   = $urandom_range(SSK_MAX_WEIGHT + 1, 100);
      end
      default: begin
        if (roll < 10) span = $urandom_range(1, 4);
        else if (roll < 25) span = $urandom_range(25, SSK_MAX_SEED_LENGTH);
        else span = $urandom_range(5, 24);
        roll = $urandom_range(0, 99);
        if (roll < 10) wt = $urandom_range(2, SSK_MIN_WEIGHT - 1);
        else if (roll < 15 && span > SSK_MAX_WEIGHT) wt = $urandom_range(SSK_MAX_WEIGHT + 1, span);
        else wt = $urandom_range(SSK_MIN_WEIGHT, (span < SSK_MAX_WEIGHT) ? span : SSK_MAX_WEIGHT);
      end
    endcase
    lv = SSK_LEN_W'(span);
    if (span == SSK_MAX_SEED_LENGTH && (ph == 2 || (ph > 3 && $urandom_range(0, 1) == 1)))
      lv = SSK_LEN_W'($urandom_range(SSK_MAX_SEED_LENGTH + 1, 255));

    // first and last offsets always selected, the rest scattered
    m = '0;
    m[0] = 1'b1;
    m[span-1] = 1'b1;
    cnt = (span == 1) ? 1 : 2;
    if (wt > span) wt = span;
    while (cnt < wt) begin
      idx = $urandom_range(1, span - 2);
      if (!m[idx]) begin
        m[idx] = 1'b1;
        cnt++;
      end
    end

    // junk above the span must be ignored
    if ($urandom_range(0, 1) == 1) begin
      junk = {$urandom, $urandom, $urandom, $urandom};
      m |= junk & ~((128'h1 << span) - 1);
    end
  endtask

  initial begin
    logic [SSK_MASK_BITS-1:0] m;
    logic [SSK_LEN_W-1:0]     lv;
    int unsigned              span, n, k, ph, rand_sent;
    logic                     cs;

    sb = new();
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= SSK_REG_MASK_LOW;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.symbol      <= '0;
    in_ch.chunk_start <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset seed spans one symbol: weight too low, counter still advances
    send_item(2'd3, 1'b0);
    send_item(2'd0, 1'b1);
    drain(4);

    // Shortest legal seed, every symbol value, then a chunk that never fills
    write_seed(128'h1F, 8'd5);
    send_item(2'd0, 1'b1);
    send_item(2'd1, 1'b0);
    send_item(2'd2, 1'b0);
    send_item(2'd3, 1'b0);
    send_item(2'd3, 1'b0);
    send_item(2'd3, 1'b0);
    send_item(2'd1, 1'b1);
    send_item(2'd2, 1'b0);
    drain(4);

    // Change the seed mid-chunk; length over the maximum, weight over the limit
    write_seed('1, 8'd200);
    send_item(2'd3, 1'b0);
    send_item(2'd0, 1'b0);
    drain(4);

    // Zero length acts as one
    write_seed('1, 8'd0);
    send_item(2'd1, 1'b0);
    send_item(2'd2, 1'b1);
    drain(4);

    // Mask bits beyond the span are ignored
    write_seed({64'hF0F0_0000_0000_0001, 64'hFFFF_0000_0000_010F}, 8'd9);
    for (k = 0; k < 10; k++) send_item(ssk_sym_t'(k % 4), k == 0);
    drain(4);

    // Random seeds, mostly well-formed chunks with random symbols
    ph = 0;
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      pick_seed(ph, m, lv, span);
      write_seed(m, lv);
      if ($urandom_range(0, 1) == 1) chunk_left = 0;
      n = (span < 5) ? 40 : ((span >= 25) ? span + 80 : 110);
      for (k = 0; k < n; k++) begin
        cs = 1'b0;
        if (chunk_left == 0) begin
          cs = 1'b1;
          chunk_left = ($urandom_range(0, 4) != 0) ? $urandom_range(span, 3 * span + 8)
                                                   : $urandom_range(1, span);
        end
        send_item(ssk_sym_t'($urandom_range(0, 3)), cs);
        chunk_left--;
      end
      rand_sent += n;
      ph++;
      drain(4);
    end
    drain(8);

    $display("run: %0d symbols under %0d seed settings, %0d keys checked",
             sb.noted, settings, sb.checked);
    $display("run: %0d mismatches in %0d cycles", sb.errors, cycles);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ssk_pkg.sv
rtl/ssk_if.sv
rtl/ssk_seed_table.sv
rtl/ssk_extract.sv
rtl/spaced_seed_key_extractor.sv
tb/testbench.sv
